// ===== design/sitoa_pkg.sv =====
`default_nettype none
package sitoa_pkg;
	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIG_W      = 4;
	localparam int NUM_DIGITS = 10;
	localparam int IDX_W      = 4;
	// Binary bits consumed per double-dabble step, and the resulting step count
	localparam int BITS_PER_STEP = 4;
	localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(NUM_STEPS);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [DIG_W-1:0]  DIGIT_MAX  = 4'd9;

	typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] bcd_t;

	// One converted number as it travels from the front to the back
	typedef struct packed {
		logic             neg;
		bcd_t             digits;
		logic [IDX_W-1:0] ndig;
	} entry_t;
endpackage
`default_nettype wire

// ===== design/signed_int_to_decimal_ascii_unit.sv =====
`default_nettype none
// Path from the input transfer to the first character on the master side:
//   (8 double-dabble steps of 4 bits each, one queue push, one back-end load, output register).
// The front takes a new number only once it has pushed the last one; the front conversion
//   and the back character emission overlap through the queue.
// Reset: arst_n clears all control state asynchronously; no clearing pass, usable at once.
module signed_int_to_decimal_ascii_unit #(
	parameter int FIFO_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave side: one signed integer per transfer
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value (two's complement)
	// Master side: one ASCII character per transfer
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] character
	output logic             m_tlast    // final character of the number's text
);
	// Front-to-queue and queue-to-back channels
	logic              push_valid;
	logic              push_ready;
	sitoa_pkg::entry_t push_entry;
	logic              pop_valid;
	logic              pop_ready;
	sitoa_pkg::entry_t pop_entry;

	// Front: take the value, split off the sign, convert the magnitude to BCD
	// four bits a cycle and count the significant digits.
	sitoa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_value   (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Queue: hold converted numbers so the front can start the next one while
	// the back is still emitting characters.
	sitoa_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// Back: emit an optional minus sign, then digits most significant first,
	// one character per transfer, through a registered output.
	sitoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);
endmodule
`default_nettype wire

// ===== design/sitoa_front.sv =====
`default_nettype none
module sitoa_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [sitoa_pkg::VALUE_W-1:0] in_value,
	output logic                             push_valid,
	input  wire logic                        push_ready,
	output sitoa_pkg::entry_t                push_entry
);
	localparam int WW = sitoa_pkg::NUM_DIGITS * sitoa_pkg::DIG_W + sitoa_pkg::VALUE_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]                        state_q;
	logic [sitoa_pkg::STEP_W-1:0]      cnt_q;
	logic                              neg_q;
	logic [sitoa_pkg::VALUE_W-1:0]     mag_q;
	sitoa_pkg::bcd_t                   bcd_q;
	logic [WW-1:0]                     dd_next;
	logic [sitoa_pkg::IDX_W-1:0]       ndig;

	// Adjust-and-shift over several binary bits: add 3 to every digit of 5 or more, shift left
	function automatic logic [WW-1:0] dd_steps(input logic [WW-1:0] w_in);
		logic [WW-1:0]               w;
		logic [sitoa_pkg::DIG_W-1:0] d;
		w = w_in;
		for (int j = 0; j < sitoa_pkg::BITS_PER_STEP; j++) begin
			for (int i = 0; i < sitoa_pkg::NUM_DIGITS; i++) begin
				d = w[sitoa_pkg::VALUE_W + i*sitoa_pkg::DIG_W +: sitoa_pkg::DIG_W];
				if (d >= 4'd5) begin
					w[sitoa_pkg::VALUE_W + i*sitoa_pkg::DIG_W +: sitoa_pkg::DIG_W] = d + 4'd3;
				end
			end
			w = w << 1;
		end
		return w;
	endfunction

	assign dd_next  = dd_steps({bcd_q, mag_q});
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		ndig = sitoa_pkg::IDX_W'(1);
		for (int i = 1; i < sitoa_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[i] != '0) begin
				ndig = sitoa_pkg::IDX_W'(i + 1);
			end
		end
	end

	assign push_valid        = (state_q == ST_PUSH);
	assign push_entry.neg    = neg_q;
	assign push_entry.digits = bcd_q;
	assign push_entry.ndig   = ndig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == sitoa_pkg::STEP_W'(sitoa_pkg::NUM_STEPS - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			neg_q <= in_value[sitoa_pkg::VALUE_W-1];
			mag_q <= in_value[sitoa_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			{bcd_q, mag_q} <= dd_next;
		end
	end
endmodule
`default_nettype wire

// ===== design/sitoa_fifo.sv =====
`default_nettype none
module sitoa_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	output logic             push_ready,
	input  wire sitoa_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  wire logic        pop_ready,
	output sitoa_pkg::entry_t pop_entry
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sitoa_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/sitoa_back.sv =====
`default_nettype none
module sitoa_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pop_valid,
	output logic                             pop_ready,
	input  wire sitoa_pkg::entry_t           pop_entry,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [sitoa_pkg::CHAR_W-1:0]     out_char,
	output logic                             out_last
);
	logic                          active_q;
	logic                          sign_q;
	logic [sitoa_pkg::IDX_W-1:0]   idx_q;
	sitoa_pkg::bcd_t               digits_q;
	logic                          out_valid_q;
	logic [sitoa_pkg::CHAR_W-1:0]  out_char_q;
	logic                          out_last_q;
	logic                          load;
	logic [sitoa_pkg::DIG_W-1:0]   cur_digit;

	assign pop_ready = !active_q;
	assign load      = active_q && (!out_valid_q || out_ready);
	assign cur_digit = digits_q[idx_q];

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!active_q && pop_valid) begin
				active_q <= 1'b1;
			end else if (load && !sign_q && idx_q == '0) begin
				active_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!active_q && pop_valid) begin
			sign_q   <= pop_entry.neg;
			idx_q    <= pop_entry.ndig - 1'b1;
			digits_q <= pop_entry.digits;
		end else if (load) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
		if (load) begin
			if (sign_q) begin
				out_char_q <= sitoa_pkg::CHAR_MINUS;
				out_last_q <= 1'b0;
			end else begin
				out_char_q <= sitoa_pkg::CHAR_ZERO + {4'h0, cur_digit};
				out_last_q <= (idx_q == '0);
			end
		end
	end

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_char_q == sitoa_pkg::CHAR_MINUS |-> !out_last_q)
		else $error("minus sign flagged as last character");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_char_q == sitoa_pkg::CHAR_MINUS) ||
		((out_char_q >= sitoa_pkg::CHAR_ZERO) &&
		 (out_char_q <= sitoa_pkg::CHAR_ZERO + {4'h0, sitoa_pkg::DIGIT_MAX})))
		else $error("character is neither a digit nor a minus sign");

	a_text_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ready && !out_last_q |=> out_valid_q)
		else $error("gap inside the text of one number");
endmodule
`default_nettype wire
